>>> design/ecmc_pkg.sv
// Package for the encoder-counted move controller.
// Holds the state and phase types, register indexes, move codes, constants and the duty clamp.
// Used by encoder_counted_move_controller, move_drive_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ecmc_pkg;

	localparam int BACK_TIMEOUT_DEF = 2400;
	localparam int TURN_TIMEOUT_DEF = 1200;

	localparam int DIV_BITS = 36;
	localparam int MUL_BITS = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_STORE,
		ST_EVAL,
		ST_MUL,
		ST_STEER,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_COMP,
		PH_RIGHT,
		PH_LEFT
	} phase_t;

	localparam logic [1:0] KIND_FWD  = 2'd0;
	localparam logic [1:0] KIND_BACK = 2'd1;
	localparam logic [1:0] KIND_TURN = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	localparam logic [2:0] CFG_BASE_SPEED = 3'd0;
	localparam logic [2:0] CFG_TURN_SPEED = 3'd1;
	localparam logic [2:0] CFG_RIGHT_MPP  = 3'd2;
	localparam logic [2:0] CFG_LEFT_MPP   = 3'd3;
	localparam logic [2:0] CFG_ARC        = 3'd4;

	localparam logic [7:0]  BASE_SPEED_RST = 8'd150;
	localparam logic [7:0]  TURN_SPEED_RST = 8'd120;
	localparam logic [15:0] MPP_RST        = 16'd4096;
	localparam logic [15:0] ARC_RST        = 16'd256;

	localparam logic [13:0] COMP_FWD_BASE = 14'd125;
	localparam logic [13:0] COMP_BACK     = 14'd120;
	localparam logic [13:0] COMP_TURN     = 14'd115;
	localparam logic [15:0] COMP_DIVISOR  = 16'd50;

	localparam logic [7:0]  DUTY_MIN = 8'd60;
	localparam logic [7:0]  DUTY_MAX = 8'd200;
	localparam logic [11:0] TICK_MAX = 12'd4095;

	function automatic logic [7:0] clamp_duty(input logic signed [38:0] v);
		logic [7:0] r;
		if (v < $signed({31'd0, DUTY_MIN})) begin
			r = DUTY_MIN;
		end else if (v > $signed({31'd0, DUTY_MAX})) begin
			r = DUTY_MAX;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/encoder_counted_move_controller.sv
// Encoder-counted two-wheel move controller, top level.
// Stop counts come from a bit-serial divider, steering from a bit-serial multiplier.
// Depends on ecmc_pkg.
// A forward start runs three divisions (compensation, right stop, left stop), a backward or
// turn start two; a forward tick with both wheels still short of their stop runs both products.
// Each division yields one quotient bit a cycle; each wheel product is formed bit-serially too.
// One item is worked on at a time; the next is taken once the result is in the output register.
// Reset clears the configuration to its defaults and leaves the block idle with no move.
`timescale 1ns / 1ps
`default_nettype none

module encoder_counted_move_controller #(
	parameter int BACK_TIMEOUT_TICKS = ecmc_pkg::BACK_TIMEOUT_DEF,
	parameter int TURN_TIMEOUT_TICKS = ecmc_pkg::TURN_TIMEOUT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// move_kind[1:0], turn_left[2], amount[18:3], right_pulses[22:19], left_pulses[26:23]
	input  wire logic [31:0] s_tdata,
	// action[0]
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// right_duty[7:0], left_duty[15:8], right_reverse[16], left_reverse[17], brake[18],
	// timed_out[19], busy_res[20]
	output logic [23:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	ecmc_pkg::state_t state_q, state_d;
	ecmc_pkg::phase_t phase_q;

	logic [7:0]  base_speed_q, turn_speed_q;
	logic [15:0] right_mpp_q, left_mpp_q, arc_q;

	logic [31:0] right_count_q, left_count_q, right_stop_q, left_stop_q;
	logic [1:0]  active_kind_q;
	logic        moving_q, turn_dir_q;
	logic [11:0] elapsed_q;
	logic [7:0]  right_duty_q, left_duty_q;
	logic        end_flag_q, tmo_flag_q;
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic [5:0]  cnt_q;
	logic        mul_right_q;

	logic [15:0] amount_q;
	logic [13:0] comp_q;
	logic [35:0] div_num_q;
	logic [15:0] div_rem_q;
	logic [15:0] div_den_q;
	logic [47:0] mul_acc_q;
	logic [15:0] mul_bits_q;
	logic [35:0] ld_q;

	logic        in_action, in_turn_left;
	logic [1:0]  in_kind;
	logic [15:0] in_amount;
	logic [3:0]  in_rpulses, in_lpulses;
	logic        accept, out_load;

	logic [16:0] rem_sh, rem_nx;
	logic        rem_ge;
	logic [35:0] num_nx;
	logic [31:0] target, stop_val;
	logic [18:0] seven_amount;
	logic [31:0] arc_prod;

	logic [32:0] rsum, lsum;
	logic        rdone, ldone, tmo_hit;
	logic [11:0] limit;

	logic [31:0] mul_src;
	logic [47:0] acc_nx;
	logic signed [36:0] diff_w;
	logic signed [38:0] base_w, twod_w;
	logic [7:0]  steer_l, steer_r;

	logic [7:0]  st_rduty, st_lduty;
	logic        st_rrev, st_lrev;

	assign in_action    = s_tuser;
	assign in_kind      = s_tdata[1:0];
	assign in_turn_left = s_tdata[2];
	assign in_amount    = s_tdata[18:3];
	assign in_rpulses   = s_tdata[22:19];
	assign in_lpulses   = s_tdata[26:23];

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Restoring division step, one quotient bit per cycle.
	assign rem_sh = {div_rem_q, div_num_q[35]};
	assign rem_ge = rem_sh >= {1'b0, div_den_q};
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, div_den_q}) : rem_sh;
	assign num_nx = {div_num_q[34:0], rem_ge};

	assign target   = (|div_num_q[35:32]) ? 32'hFFFF_FFFF : div_num_q[31:0];
	assign stop_val = (target < {18'd0, comp_q}) ? target : (target - {18'd0, comp_q});

	assign seven_amount = {amount_q, 3'b000} - {3'b000, amount_q};
	assign arc_prod     = {16'd0, amount_q} * {16'd0, arc_q};

	assign rsum = {1'b0, right_count_q} + {29'd0, in_rpulses};
	assign lsum = {1'b0, left_count_q} + {29'd0, in_lpulses};

	assign rdone   = right_count_q >= right_stop_q;
	assign ldone   = left_count_q >= left_stop_q;
	assign limit   = (active_kind_q == ecmc_pkg::KIND_BACK) ? 12'(BACK_TIMEOUT_TICKS)
		: 12'(TURN_TIMEOUT_TICKS);
	assign tmo_hit = (active_kind_q != ecmc_pkg::KIND_FWD) && (elapsed_q > limit);

	// Shift-and-add product of a wheel count and its travel per pulse, MSB of the factor first.
	assign mul_src = mul_right_q ? right_count_q : left_count_q;
	assign acc_nx  = {mul_acc_q[46:0], 1'b0} + (mul_bits_q[15] ? {16'd0, mul_src} : 48'd0);

	assign diff_w  = $signed({1'b0, ld_q}) - $signed({1'b0, mul_acc_q[47:12]});
	assign base_w  = $signed({31'd0, base_speed_q});
	assign twod_w  = $signed({diff_w[36], diff_w, 1'b0});
	assign steer_l = ecmc_pkg::clamp_duty(base_w - twod_w);
	assign steer_r = ecmc_pkg::clamp_duty(base_w + twod_w);

	always_comb begin
		st_rduty = 8'd0;
		st_lduty = 8'd0;
		st_rrev  = 1'b0;
		st_lrev  = 1'b0;
		if (moving_q) begin
			st_rduty = right_duty_q;
			st_lduty = left_duty_q;
			case (active_kind_q)
				ecmc_pkg::KIND_FWD: begin
					st_rrev = 1'b0;
					st_lrev = 1'b1;
				end
				ecmc_pkg::KIND_BACK: begin
					st_rrev = 1'b1;
					st_lrev = 1'b0;
				end
				default: begin
					st_rrev = !turn_dir_q;
					st_lrev = !turn_dir_q;
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ecmc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (in_action == ecmc_pkg::ACT_START) begin
						state_d = (in_kind == ecmc_pkg::KIND_NONE) ? ecmc_pkg::ST_EMIT
							: ecmc_pkg::ST_PREP;
					end else begin
						state_d = moving_q ? ecmc_pkg::ST_EVAL : ecmc_pkg::ST_EMIT;
					end
				end
			end
			ecmc_pkg::ST_PREP: begin
				state_d = ecmc_pkg::ST_DIV;
			end
			ecmc_pkg::ST_DIV: begin
				if (cnt_q == 6'd0) begin
					state_d = ecmc_pkg::ST_STORE;
				end
			end
			ecmc_pkg::ST_STORE: begin
				state_d = (phase_q == ecmc_pkg::PH_LEFT) ? ecmc_pkg::ST_EVAL
					: ecmc_pkg::ST_PREP;
			end
			ecmc_pkg::ST_EVAL: begin
				if ((rdone && ldone) || tmo_hit) begin
					state_d = ecmc_pkg::ST_EMIT;
				end else if (active_kind_q == ecmc_pkg::KIND_FWD && !rdone && !ldone) begin
					state_d = ecmc_pkg::ST_MUL;
				end else begin
					state_d = ecmc_pkg::ST_EMIT;
				end
			end
			ecmc_pkg::ST_MUL: begin
				if (cnt_q == 6'd0 && mul_right_q) begin
					state_d = ecmc_pkg::ST_STEER;
				end
			end
			ecmc_pkg::ST_STEER: begin
				state_d = ecmc_pkg::ST_EMIT;
			end
			ecmc_pkg::ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ecmc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ecmc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = (state_q == ecmc_pkg::ST_IDLE);
		out_load = (state_q == ecmc_pkg::ST_EMIT) && (!m_tvalid_q || m_tready);
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ecmc_pkg::ST_IDLE;
			phase_q       <= ecmc_pkg::PH_COMP;
			base_speed_q  <= ecmc_pkg::BASE_SPEED_RST;
			turn_speed_q  <= ecmc_pkg::TURN_SPEED_RST;
			right_mpp_q   <= ecmc_pkg::MPP_RST;
			left_mpp_q    <= ecmc_pkg::MPP_RST;
			arc_q         <= ecmc_pkg::ARC_RST;
			right_count_q <= 32'd0;
			left_count_q  <= 32'd0;
			right_stop_q  <= 32'd0;
			left_stop_q   <= 32'd0;
			active_kind_q <= ecmc_pkg::KIND_FWD;
			moving_q      <= 1'b0;
			turn_dir_q    <= 1'b0;
			elapsed_q     <= 12'd0;
			right_duty_q  <= 8'd0;
			left_duty_q   <= 8'd0;
			end_flag_q    <= 1'b0;
			tmo_flag_q    <= 1'b0;
			m_tvalid_q    <= 1'b0;
			cnt_q         <= 6'd0;
			mul_right_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ecmc_pkg::CFG_BASE_SPEED: base_speed_q <= cfg_data[7:0];
					ecmc_pkg::CFG_TURN_SPEED: turn_speed_q <= cfg_data[7:0];
					ecmc_pkg::CFG_RIGHT_MPP:  right_mpp_q  <= cfg_data;
					ecmc_pkg::CFG_LEFT_MPP:   left_mpp_q   <= cfg_data;
					ecmc_pkg::CFG_ARC:        arc_q        <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ecmc_pkg::ST_IDLE: begin
					if (accept) begin
						end_flag_q <= 1'b0;
						tmo_flag_q <= 1'b0;
						if (in_action == ecmc_pkg::ACT_START) begin
							if (in_kind != ecmc_pkg::KIND_NONE) begin
								active_kind_q <= in_kind;
								turn_dir_q    <= in_turn_left;
								right_count_q <= 32'd0;
								left_count_q  <= 32'd0;
								elapsed_q     <= 12'd0;
								moving_q      <= 1'b1;
								if (in_kind == ecmc_pkg::KIND_TURN) begin
									right_duty_q <= turn_speed_q;
									left_duty_q  <= turn_speed_q;
								end else begin
									right_duty_q <= base_speed_q;
									left_duty_q  <= base_speed_q;
								end
								phase_q <= (in_kind == ecmc_pkg::KIND_FWD) ? ecmc_pkg::PH_COMP
									: ecmc_pkg::PH_RIGHT;
							end
						end else if (moving_q) begin
							right_count_q <= rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
							left_count_q  <= lsum[32] ? 32'hFFFF_FFFF : lsum[31:0];
							if (elapsed_q != ecmc_pkg::TICK_MAX) begin
								elapsed_q <= elapsed_q + 12'd1;
							end
						end
					end
				end
				ecmc_pkg::ST_PREP: begin
					cnt_q <= 6'(ecmc_pkg::DIV_BITS - 1);
				end
				ecmc_pkg::ST_DIV: begin
					cnt_q <= cnt_q - 6'd1;
				end
				ecmc_pkg::ST_STORE: begin
					case (phase_q)
						ecmc_pkg::PH_COMP: phase_q <= ecmc_pkg::PH_RIGHT;
						ecmc_pkg::PH_RIGHT: begin
							right_stop_q <= stop_val;
							phase_q      <= ecmc_pkg::PH_LEFT;
						end
						default: left_stop_q <= stop_val;
					endcase
				end
				ecmc_pkg::ST_EVAL: begin
					if ((rdone && ldone) || tmo_hit) begin
						moving_q     <= 1'b0;
						right_duty_q <= 8'd0;
						left_duty_q  <= 8'd0;
						end_flag_q   <= 1'b1;
						tmo_flag_q   <= !(rdone && ldone);
					end else if (active_kind_q == ecmc_pkg::KIND_FWD && !rdone && !ldone) begin
						cnt_q       <= 6'(ecmc_pkg::MUL_BITS - 1);
						mul_right_q <= 1'b0;
					end else begin
						if (rdone) begin
							right_duty_q <= 8'd0;
						end
						if (ldone) begin
							left_duty_q <= 8'd0;
						end
					end
				end
				ecmc_pkg::ST_MUL: begin
					if (cnt_q == 6'd0 && !mul_right_q) begin
						mul_right_q <= 1'b1;
						cnt_q       <= 6'(ecmc_pkg::MUL_BITS - 1);
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ecmc_pkg::ST_STEER: begin
					right_duty_q <= steer_r;
					left_duty_q  <= steer_l;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ecmc_pkg::ST_IDLE: begin
				if (accept) begin
					amount_q <= in_amount;
					comp_q   <= (in_kind == ecmc_pkg::KIND_TURN) ? ecmc_pkg::COMP_TURN
						: ecmc_pkg::COMP_BACK;
				end
			end
			ecmc_pkg::ST_PREP: begin
				div_rem_q <= 16'd0;
				case (phase_q)
					ecmc_pkg::PH_COMP: begin
						div_num_q <= {17'd0, seven_amount};
						div_den_q <= ecmc_pkg::COMP_DIVISOR;
					end
					default: begin
						if (active_kind_q == ecmc_pkg::KIND_TURN) begin
							div_num_q <= {arc_prod, 4'd0};
						end else begin
							div_num_q <= {8'd0, amount_q, 12'd0};
						end
						div_den_q <= (phase_q == ecmc_pkg::PH_RIGHT) ? right_mpp_q : left_mpp_q;
					end
				endcase
			end
			ecmc_pkg::ST_DIV: begin
				div_rem_q <= rem_nx[15:0];
				div_num_q <= num_nx;
			end
			ecmc_pkg::ST_STORE: begin
				if (phase_q == ecmc_pkg::PH_COMP) begin
					comp_q <= ecmc_pkg::COMP_FWD_BASE + div_num_q[13:0];
				end
			end
			ecmc_pkg::ST_EVAL: begin
				mul_acc_q  <= 48'd0;
				mul_bits_q <= left_mpp_q;
			end
			ecmc_pkg::ST_MUL: begin
				if (cnt_q == 6'd0 && !mul_right_q) begin
					ld_q       <= acc_nx[47:12];
					mul_acc_q  <= 48'd0;
					mul_bits_q <= right_mpp_q;
				end else begin
					mul_acc_q  <= acc_nx;
					mul_bits_q <= {mul_bits_q[14:0], 1'b0};
				end
			end
			ecmc_pkg::ST_EMIT: begin
				if (out_load) begin
					m_tdata_q <= {3'd0, moving_q, tmo_flag_q, end_flag_q, st_lrev, st_rrev,
						st_lduty, st_rduty};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> dv/move_drive_checker.sv
// Checker for the encoder-counted move controller: watches the input, result and register
// write channels, predicts each result from its own model of the moves and compares them.
// Depends on ecmc_pkg.
`timescale 1ns / 1ps

module move_drive_checker #(
	parameter int BACK_LIMIT = ecmc_pkg::BACK_TIMEOUT_DEF,
	parameter int TURN_LIMIT = ecmc_pkg::TURN_TIMEOUT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fails,
	output int          pending,
	output int          moved_items,
	output int          moves_ended,
	output int          moves_timed_out,
	output int          results_checked
);

	import ecmc_pkg::*;

	typedef struct packed {
		logic       busy;
		logic       timed_out;
		logic       brake;
		logic       left_rev;
		logic       right_rev;
		logic [7:0] left_duty;
		logic [7:0] right_duty;
	} wheel_drive_t;

	wheel_drive_t drive_due[$];

	logic [7:0]  base_spd, turn_spd;
	logic [15:0] right_mpp, left_mpp, arc_q88;
	logic [31:0] right_cnt, left_cnt, right_stop, left_stop;
	logic [1:0]  kind_now;
	logic        in_motion, dir_left;
	logic [11:0] ticks_run;
	logic [7:0]  right_held, left_held;
	int          worked;

	function automatic logic [31:0] quot_sat(logic [63:0] num, logic [15:0] den);
		logic [63:0] q;
		if (den == '0) return '1;
		q = num / 64'(den);
		return (q > 64'h0000_0000_FFFF_FFFF) ? '1 : q[31:0];
	endfunction

	function automatic logic [31:0] stop_count(logic [31:0] target, logic [31:0] comp);
		return (target < comp) ? target : target - comp;
	endfunction

	function automatic logic [31:0] add_sat(logic [31:0] a, logic [3:0] b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic [7:0] duty_limit(longint v);
		if (v < longint'(DUTY_MIN)) return DUTY_MIN;
		if (v > longint'(DUTY_MAX)) return DUTY_MAX;
		return v[7:0];
	endfunction

	function automatic wheel_drive_t status_now();
		wheel_drive_t r;
		r = '0;
		if (!in_motion) return r;
		r.right_duty = right_held;
		r.left_duty = left_held;
		case (kind_now)
			KIND_FWD: begin
				r.right_rev = 1'b0;
				r.left_rev = 1'b1;
			end
			KIND_BACK: begin
				r.right_rev = 1'b1;
				r.left_rev = 1'b0;
			end
			default: begin
				r.right_rev = !dir_left;
				r.left_rev = !dir_left;
			end
		endcase
		r.busy = 1'b1;
		return r;
	endfunction

	function automatic wheel_drive_t wrap_up(logic by_timeout);
		wheel_drive_t r;
		in_motion = 1'b0;
		right_held = '0;
		left_held = '0;
		r = '0;
		r.brake = 1'b1;
		r.timed_out = by_timeout;
		moves_ended++;
		if (by_timeout) moves_timed_out++;
		return r;
	endfunction

	function automatic wheel_drive_t settle_move();
		logic   rdone, ldone;
		int     limit;
		longint ltrav, rtrav, diff;
		rdone = right_cnt >= right_stop;
		ldone = left_cnt >= left_stop;
		limit = (kind_now == KIND_BACK) ? BACK_LIMIT : TURN_LIMIT;
		if (rdone && ldone) return wrap_up(1'b0);
		if (kind_now != KIND_FWD && int'(ticks_run) > limit) return wrap_up(1'b1);
		if (kind_now == KIND_FWD && !rdone && !ldone) begin
			ltrav = longint'((64'(left_cnt) * 64'(left_mpp)) >> 12);
			rtrav = longint'((64'(right_cnt) * 64'(right_mpp)) >> 12);
			diff = ltrav - rtrav;
			left_held = duty_limit(longint'(base_spd) - 2 * diff);
			right_held = duty_limit(longint'(base_spd) + 2 * diff);
		end else begin
			if (rdone) right_held = '0;
			if (ldone) left_held = '0;
		end
		return status_now();
	endfunction

	function automatic wheel_drive_t predict_drive(logic act, logic [1:0] kind, logic tl,
			logic [15:0] amt, logic [3:0] rp, logic [3:0] lp);
		logic [63:0] num;
		logic [31:0] comp;
		logic [7:0]  spd;
		if (act == ACT_START) begin
			if (kind == KIND_NONE) return status_now();
			if (kind == KIND_TURN) begin
				num = 64'(amt) * 64'(arc_q88) * 64'd16;
				comp = 32'(COMP_TURN);
				spd = turn_spd;
			end else begin
				num = 64'(amt) << 12;
				comp = (kind == KIND_FWD) ?
					32'(COMP_FWD_BASE) + 32'd7 * 32'(amt) / 32'(COMP_DIVISOR) : 32'(COMP_BACK);
				spd = base_spd;
			end
			right_stop = stop_count(quot_sat(num, right_mpp), comp);
			left_stop = stop_count(quot_sat(num, left_mpp), comp);
			right_cnt = '0;
			left_cnt = '0;
			ticks_run = '0;
			kind_now = kind;
			dir_left = tl;
			right_held = spd;
			left_held = spd;
			in_motion = 1'b1;
			worked++;
			return settle_move();
		end
		if (!in_motion) return status_now();
		worked++;
		right_cnt = add_sat(right_cnt, rp);
		left_cnt = add_sat(left_cnt, lp);
		if (ticks_run < TICK_MAX) ticks_run++;
		return settle_move();
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic check_result(logic [20:0] raw);
		wheel_drive_t got, want;
		got = wheel_drive_t'(raw);
		if (drive_due.size() == 0) begin
			$error("result transfer with no expected result waiting");
			fails++;
		end else begin
			want = drive_due.pop_front();
			check_field("right_duty", want.right_duty, got.right_duty);
			check_field("left_duty", want.left_duty, got.left_duty);
			check_field("right_reverse", want.right_rev, got.right_rev);
			check_field("left_reverse", want.left_rev, got.left_rev);
			check_field("brake", want.brake, got.brake);
			check_field("timed_out", want.timed_out, got.timed_out);
			check_field("busy_res", want.busy, got.busy);
			results_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_spd = BASE_SPEED_RST;
			turn_spd = TURN_SPEED_RST;
			right_mpp = MPP_RST;
			left_mpp = MPP_RST;
			arc_q88 = ARC_RST;
			right_cnt = '0;
			left_cnt = '0;
			right_stop = '0;
			left_stop = '0;
			kind_now = KIND_FWD;
			in_motion = 1'b0;
			dir_left = 1'b0;
			ticks_run = '0;
			right_held = '0;
			left_held = '0;
			drive_due.delete();
			worked = 0;
			fails = 0;
			moves_ended = 0;
			moves_timed_out = 0;
			results_checked = 0;
			pending <= 0;
			moved_items <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BASE_SPEED: base_spd = cfg_data[7:0];
					CFG_TURN_SPEED: turn_spd = cfg_data[7:0];
					CFG_RIGHT_MPP:  right_mpp = cfg_data;
					CFG_LEFT_MPP:   left_mpp = cfg_data;
					CFG_ARC:        arc_q88 = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) check_result(m_tdata[20:0]);
			if (s_tvalid && s_tready) begin
				drive_due.push_back(predict_drive(s_tuser, s_tdata[1:0], s_tdata[2],
					s_tdata[18:3], s_tdata[22:19], s_tdata[26:23]));
			end
			pending <= drive_due.size();
			moved_items <= worked;
		end
	end

endmodule

>>> dv/encoder_counted_move_controller_tb.sv
// Testbench top for the encoder-counted move controller: clock, reset, move and tick
// stimulus, register settings, receiver stalls and the verdict.
// Depends on ecmc_pkg, encoder_counted_move_controller and move_drive_checker.
`timescale 1ns / 1ps

module encoder_counted_move_controller_tb;

	import ecmc_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [31:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int fails, pending, moved_items, moves_ended, moves_timed_out, results_checked;
	int items_sent, reg_writes, settings_used, burst_left;
	int cycle_count = 0;
	bit hold_off_req;
	logic [15:0] mpp_right, mpp_left, arc_now;

	always #5 clk = ~clk;

	encoder_counted_move_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	move_drive_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fails           (fails),
		.pending         (pending),
		.moved_items     (moved_items),
		.moves_ended     (moves_ended),
		.moves_timed_out (moves_timed_out),
		.results_checked (results_checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL encoder_counted_move_controller");
			$finish;
		end
	end

	// The receiver changes its stall style now and then, and serves a long hold-off on request.
	initial begin
		int span, style;
		m_tready <= 1'b0;
		forever begin
			span = $urandom_range(20, 300);
			style = $urandom_range(0, 3);
			repeat (span) begin
				@(posedge clk);
				if (hold_off_req) begin
					m_tready <= 1'b0;
					repeat (600) @(posedge clk);
					hold_off_req = 1'b0;
				end else begin
					case (style)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= ~m_tready;
					endcase
				end
			end
		end
	end

	task automatic push_item(logic act, logic [1:0] kind, logic tl, logic [15:0] amt,
			logic [3:0] rp, logic [3:0] lp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if ($urandom_range(0, 9) == 0) gap = $urandom_range(60, 200);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {5'd0, lp, rp, amt, tl, kind};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		items_sent++;
	endtask

	task automatic push_tick(int mode);
		logic [3:0] rp, lp;
		case (mode)
			1: begin
				rp = 4'($urandom_range(8, 15));
				lp = 4'($urandom_range(0, 7));
			end
			2: begin
				rp = 4'($urandom_range(0, 7));
				lp = 4'($urandom_range(8, 15));
			end
			3: begin
				rp = 4'($urandom_range(0, 3));
				lp = 4'($urandom_range(0, 3));
			end
			default: begin
				rp = 4'($urandom);
				lp = 4'($urandom);
			end
		endcase
		push_item(ACT_TICK, 2'($urandom), 1'($urandom), 16'($urandom), rp, lp);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	task automatic write_setting(logic [7:0] base, logic [7:0] turn, logic [15:0] rmpp,
			logic [15:0] lmpp, logic [15:0] arc);
		drain_results();
		put_reg(CFG_BASE_SPEED, {8'($urandom), base});
		put_reg(CFG_TURN_SPEED, {8'($urandom), turn});
		put_reg(CFG_RIGHT_MPP, rmpp);
		put_reg(CFG_LEFT_MPP, lmpp);
		put_reg(CFG_ARC, arc);
		cfg_valid <= 1'b0;
		mpp_right = rmpp;
		mpp_left = lmpp;
		arc_now = arc;
		settings_used++;
	endtask

	// Rough number of ticks a move needs at an average of seven pulses a tick.
	function automatic int tick_budget(logic [1:0] kind, logic [15:0] amt);
		logic [63:0] num, need;
		logic [15:0] den;
		den = (mpp_right < mpp_left) ? mpp_right : mpp_left;
		if (den == '0) return 60;
		num = (kind == KIND_TURN) ? 64'(amt) * 64'(arc_now) * 64'd16 : 64'(amt) << 12;
		need = num / 64'(den) / 64'd7 + 64'd2;
		return (need > 64'd60) ? 60 : int'(need);
	endfunction

	task automatic run_move();
		logic [1:0]  kind;
		logic [15:0] amt;
		int          roll, n, mode;
		if ($urandom_range(0, 9) == 0) push_tick(0);
		roll = $urandom_range(0, 99);
		kind = (roll < 45) ? KIND_FWD : (roll < 70) ? KIND_BACK :
			(roll < 95) ? KIND_TURN : KIND_NONE;
		roll = $urandom_range(0, 99);
		amt = (roll < 70) ? 16'($urandom_range(0, 400)) :
			(roll < 85) ? 16'($urandom_range(0, 31)) : 16'($urandom);
		push_item(ACT_START, kind, 1'($urandom), amt, 4'($urandom), 4'($urandom));
		if (kind == KIND_NONE) return;
		n = tick_budget(kind, amt);
		if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
		n += $urandom_range(0, 2);
		mode = $urandom_range(0, 3);
		repeat (n) push_tick(mode);
	endtask

	initial begin
		int p, goal, w;
		bit paused;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		hold_off_req = 1'b0;
		burst_left = 0;
		items_sent = 0;
		reg_writes = 0;
		settings_used = 0;
		mpp_right = MPP_RST;
		mpp_left = MPP_RST;
		arc_now = ARC_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd15, 4'd15);
		push_item(ACT_START, KIND_NONE, 1'b1, 16'hFFFF, 4'd0, 4'd0);
		push_item(ACT_START, KIND_FWD, 1'b0, 16'd0, 4'd0, 4'd0);
		push_item(ACT_START, KIND_FWD, 1'b0, 16'hFFFF, 4'd0, 4'd0);
		repeat (3) push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd15, 4'd0);
		push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd0, 4'd15);
		push_item(ACT_START, KIND_NONE, 1'b0, 16'd0, 4'd0, 4'd0);
		push_item(ACT_START, KIND_BACK, 1'b0, 16'd100, 4'd0, 4'd0);
		repeat (7) push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd15, 4'd15);
		push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd15, 4'd15);
		push_item(ACT_START, KIND_TURN, 1'b1, 16'd1, 4'd0, 4'd0);
		push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd1, 4'd0);
		push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd0, 4'd1);
		push_item(ACT_START, KIND_TURN, 1'b0, 16'd0, 4'd0, 4'd0);
		// Zero travel per pulse on the right and a saturating turn target on the left.
		write_setting(BASE_SPEED_RST, TURN_SPEED_RST, 16'd0, 16'd1, 16'hFFFF);
		push_item(ACT_START, KIND_TURN, 1'b0, 16'hFFFF, 4'd0, 4'd0);
		push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd15, 4'd15);
		push_item(ACT_START, KIND_FWD, 1'b0, 16'd1, 4'd0, 4'd0);
		push_item(ACT_TICK, KIND_FWD, 1'b0, 16'd0, 4'd15, 4'd15);

		for (p = 0; p < 6; p++) begin
			case (p)
				0: write_setting(BASE_SPEED_RST, TURN_SPEED_RST, MPP_RST, MPP_RST, ARC_RST);
				1: write_setting(8'd255, 8'd255, 16'd1, 16'hFFFF, 16'hFFFF);
				2: write_setting(8'd0, 8'd0, 16'hFFFF, 16'd1, 16'd0);
				default: write_setting(8'($urandom), 8'($urandom),
					16'($urandom_range(1500, 12000)), 16'($urandom_range(1500, 12000)),
					16'($urandom_range(64, 1024)));
			endcase
			if (p == 3) hold_off_req = 1'b1;
			goal = moved_items + 190;
			paused = 1'b0;
			while (moved_items < goal) begin
				if (p == 4 && !paused && moved_items > goal - 95) begin
					drain_results();
					paused = 1'b1;
				end
				run_move();
			end
		end

		s_tvalid <= 1'b0;
		w = 0;
		do begin
			@(posedge clk);
			w++;
		end while (pending != 0 && w < 100000);
		repeat (200) @(posedge clk);
		if (pending != 0) $error("%0d expected results never arrived", pending);
		$display("Run covered %0d accepted items (%0d acting on a move),",
			items_sent, moved_items);
		$display("%0d register writes over %0d settings and %0d results checked.",
			reg_writes, settings_used, results_checked);
		$display("%0d moves ended, %0d of them by timeout.", moves_ended, moves_timed_out);
		if (fails == 0 && pending == 0) begin
			$display("PASS encoder_counted_move_controller");
		end else begin
			$display("FAIL encoder_counted_move_controller");
		end
		$finish;
	end

endmodule

>>> encoder_counted_move_controller.f
design/ecmc_pkg.sv
design/encoder_counted_move_controller.sv
dv/move_drive_checker.sv
dv/encoder_counted_move_controller_tb.sv
